// ===== hdl/poly1305_aead_mac_top_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef POLY1305_AEAD_MAC_TOP_MACROS_SVH
`define POLY1305_AEAD_MAC_TOP_MACROS_SVH

// Checked only while out of reset.
`define PAM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PAM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pam_pkg.sv =====
package pam_pkg;

	localparam int unsigned BlockBits  = 128;
	localparam int unsigned AccBits    = 131;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QPtrBits   = 2;

	localparam logic [127:0] R_CLAMP = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;

	typedef enum logic [1:0] {
		OP_AAD    = 2'd0,
		OP_TEXT   = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_R_LOW  = 3'd0,
		CFG_R_HIGH = 3'd1,
		CFG_S_LOW  = 3'd2,
		CFG_S_HIGH = 3'd3,
		CFG_MODE   = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_PAD,
		F_LEN,
		F_FIN
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_RED,
		B_SEL,
		B_TAG
	} back_state_t;

	// One unit of back-end work: absorb a block, or finalize the tag.
	typedef struct packed {
		logic                 fin;
		logic                 top;
		logic [BlockBits-1:0] blk;
	} job_t;

endpackage

// ===== hdl/pam_front.sv =====
module pam_front #(
	parameter int unsigned LenBits = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,
	input  logic              aead_mode,
	input  logic              q_full,
	output logic              push,
	output pam_pkg::job_t     job
);

	pam_pkg::front_state_t state_q, state_nx;
	logic [3:0]            fill_q;
	logic [127:0]          buf_q;
	logic [LenBits-1:0]    assoc_q, text_q;
	logic                  started_q;

	pam_pkg::op_t op;
	logic [7:0]   data_byte;
	logic         acc;
	logic [127:0] pad_blk;
	logic [127:0] full_blk;
	logic         aad_live;

	assign op        = pam_pkg::op_t'(s_tdata[1:0]);
	assign data_byte = s_tdata[9:2];
	assign s_tready  = (state_q == pam_pkg::F_IDLE) && !q_full;
	assign acc       = s_tvalid && s_tready;
	assign aad_live  = aead_mode && !started_q;
	assign full_blk  = {data_byte, buf_q[119:0]};

	// Keep buffered bytes, mark the plain-mode terminator, zero the rest.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (4'(i) < fill_q)
				pad_blk[i*8 +: 8] = buf_q[i*8 +: 8];
			else if (4'(i) == fill_q && !aead_mode)
				pad_blk[i*8 +: 8] = 8'h01;
			else
				pad_blk[i*8 +: 8] = 8'h00;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pam_pkg::F_IDLE: begin
				if (acc && op == pam_pkg::OP_FINISH)
					state_nx = pam_pkg::F_PAD;
			end
			pam_pkg::F_PAD: begin
				if (fill_q == 4'd0 || !q_full)
					state_nx = aead_mode ? pam_pkg::F_LEN : pam_pkg::F_FIN;
			end
			pam_pkg::F_LEN: begin
				if (!q_full)
					state_nx = pam_pkg::F_FIN;
			end
			pam_pkg::F_FIN: begin
				if (!q_full)
					state_nx = pam_pkg::F_IDLE;
			end
			default: state_nx = pam_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		push = 1'b0;
		job  = '0;
		case (state_q)
			pam_pkg::F_IDLE: begin
				if (acc) begin
					case (op)
						pam_pkg::OP_AAD: begin
							if (aad_live && fill_q == 4'd15) begin
								push = 1'b1;
								job  = '{fin: 1'b0, top: 1'b1, blk: full_blk};
							end
						end
						pam_pkg::OP_TEXT: begin
							if (aad_live && fill_q != 4'd0) begin
								push = 1'b1;
								job  = '{fin: 1'b0, top: 1'b1, blk: pad_blk};
							end else if (fill_q == 4'd15) begin
								push = 1'b1;
								job  = '{fin: 1'b0, top: 1'b1, blk: full_blk};
							end
						end
						default: ;
					endcase
				end
			end
			pam_pkg::F_PAD: begin
				if (fill_q != 4'd0 && !q_full) begin
					push = 1'b1;
					job  = '{fin: 1'b0, top: aead_mode, blk: pad_blk};
				end
			end
			pam_pkg::F_LEN: begin
				if (!q_full) begin
					push = 1'b1;
					job  = '{fin: 1'b0, top: 1'b1, blk: {64'(text_q), 64'(assoc_q)}};
				end
			end
			pam_pkg::F_FIN: begin
				if (!q_full) begin
					push = 1'b1;
					job  = '{fin: 1'b1, top: 1'b0, blk: '0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pam_pkg::F_IDLE;
			fill_q    <= '0;
			assoc_q   <= '0;
			text_q    <= '0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				pam_pkg::F_IDLE: begin
					if (acc && op == pam_pkg::OP_AAD && aad_live) begin
						fill_q  <= fill_q + 4'd1;
						assoc_q <= assoc_q + 1'b1;
					end
					if (acc && op == pam_pkg::OP_TEXT) begin
						// pending associated data is flushed by the padded block
						fill_q    <= (aad_live && fill_q != 4'd0) ? 4'd1 : fill_q + 4'd1;
						text_q    <= text_q + 1'b1;
						started_q <= 1'b1;
					end
				end
				pam_pkg::F_PAD: begin
					if (fill_q != 4'd0 && !q_full)
						fill_q <= '0;
				end
				pam_pkg::F_FIN: begin
					if (!q_full) begin
						fill_q    <= '0;
						assoc_q   <= '0;
						text_q    <= '0;
						started_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && op == pam_pkg::OP_AAD && aad_live)
			buf_q[fill_q*8 +: 8] <= data_byte;
		if (acc && op == pam_pkg::OP_TEXT) begin
			if (aad_live && fill_q != 4'd0)
				buf_q[7:0] <= data_byte;
			else
				buf_q[fill_q*8 +: 8] <= data_byte;
		end
	end

endmodule

// ===== hdl/pam_queue.sv =====
module pam_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pam_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output logic          rd_valid,
	output pam_pkg::job_t rd_job
);

	pam_pkg::job_t                 mem_q [pam_pkg::QueueDepth];
	logic [pam_pkg::QPtrBits-1:0]  wr_ptr_q, rd_ptr_q;
	logic [pam_pkg::QPtrBits:0]    count_q;
	logic                          do_push, do_pop;

	assign full     = count_q == (pam_pkg::QPtrBits+1)'(pam_pkg::QueueDepth);
	assign rd_valid = count_q != '0;
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

// ===== hdl/pam_back.sv =====
module pam_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  pam_pkg::job_t q_job,
	output logic          pop,
	input  logic [127:0]  r_key,
	input  logic [127:0]  s_key,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata
);

	pam_pkg::back_state_t          state_q, state_nx;
	logic [pam_pkg::AccBits-1:0]   h_q, acc_q;
	logic [pam_pkg::AccBits:0]     a_q;
	logic [3:0]                    dig_q;
	logic [127:0]                  tag_q;
	logic                          out_valid_q;

	logic [7:0]                    digit;
	logic [139:0]                  prod;
	logic [140:0]                  t_sum;
	logic [pam_pkg::AccBits-1:0]   t_red;
	logic [pam_pkg::AccBits-1:0]   h_red;
	logic [pam_pkg::AccBits-1:0]   g_sum;
	logic                          tag_load;

	// Horner over r, one byte per cycle from the top, folding 2^130 back as 5.
	assign digit = r_key[dig_q*8 +: 8];
	assign prod  = 140'(a_q) * 140'(digit);
	assign t_sum = 141'({acc_q, 8'h00}) + 141'(prod);
	assign t_red = pam_pkg::AccBits'(t_sum[129:0]) + pam_pkg::AccBits'(14'(t_sum[140:130]) * 14'd5);
	assign h_red = pam_pkg::AccBits'(h_q[129:0]) + pam_pkg::AccBits'({h_q[130], 2'b00} + {2'b00, h_q[130]});
	assign g_sum = h_q + pam_pkg::AccBits'(5);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tag_q;
	assign tag_load = (state_q == pam_pkg::B_TAG) && (!out_valid_q || m_tready);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pam_pkg::B_IDLE: begin
				if (q_valid)
					state_nx = q_job.fin ? pam_pkg::B_RED : pam_pkg::B_MUL;
			end
			pam_pkg::B_MUL: begin
				if (dig_q == 4'd0)
					state_nx = pam_pkg::B_IDLE;
			end
			pam_pkg::B_RED: state_nx = pam_pkg::B_SEL;
			pam_pkg::B_SEL: state_nx = pam_pkg::B_TAG;
			pam_pkg::B_TAG: begin
				if (tag_load)
					state_nx = pam_pkg::B_IDLE;
			end
			default: state_nx = pam_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == pam_pkg::B_IDLE) && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pam_pkg::B_IDLE;
			h_q         <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				pam_pkg::B_IDLE: begin
					if (q_valid && !q_job.fin)
						dig_q <= 4'd15;
				end
				pam_pkg::B_MUL: begin
					dig_q <= dig_q - 4'd1;
					if (dig_q == 4'd0)
						h_q <= t_red;
				end
				pam_pkg::B_RED: h_q <= h_red;
				pam_pkg::B_SEL: begin
					if (g_sum[130])
						h_q <= {1'b0, g_sum[129:0]};
				end
				pam_pkg::B_TAG: begin
					if (tag_load)
						h_q <= '0;
				end
				default: ;
			endcase
			if (tag_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !q_job.fin) begin
			a_q   <= (pam_pkg::AccBits+1)'(h_q) + (pam_pkg::AccBits+1)'({q_job.top, q_job.blk});
			acc_q <= '0;
		end else if (state_q == pam_pkg::B_MUL) begin
			acc_q <= t_red;
		end
		if (tag_load)
			tag_q <= h_q[127:0] + s_key;
	end

endmodule

// ===== hdl/poly1305_aead_mac_top.sv =====
// Poly1305 tag engine, fed one byte per input transaction.
// Input s_t*: tdata[1:0] op (0 associated data, 1 text, 2 finish, 3 ignored),
// tdata[9:2] byte. Output m_t*: one transaction per finish, tdata[63:0] tag
// bytes 0..7 and tdata[127:64] tag bytes 8..15, little endian.
// Configuration cfg_*: index 0..3 key words (r low, r high, s low, s high),
// index 4 AEAD framing in bit 0; write only while the block is idle.
// Each completed 16-byte block goes through a 4-entry queue to the multiply
// unit, which loads the block and then forms one 132x8 partial product per
// byte of r. The multiply unit takes a new block only once the last one is
// through; the queue lets the front keep taking bytes in the meantime.
// A finish holds off input while the front works through its pad, length
// (AEAD framing only) and finalize states, each of which can wait while the
// queue is full. After the finalize job leaves the queue, the back end passes
// through its reduce, select and tag states and then registers the tag.
// The front stops taking bytes while the queue is full.
// If the receiver stalls, the tag is held in the output register and further
// blocks keep running until the next tag needs that register.
// Reset clears keys, mode, counters, accumulator and the output valid.
module poly1305_aead_mac_top #(
	parameter int unsigned LENGTH_COUNTER_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [1:0] op, [9:2] data_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] tag_low, [127:64] tag_high
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	logic [63:0]   key_r_low_q, key_r_high_q, key_s_low_q, key_s_high_q;
	logic          aead_mode_q;
	logic          q_full, push, q_valid, pop;
	pam_pkg::job_t wr_job, rd_job;
	logic [127:0]  r_key;

	assign cfg_ready = 1'b1;
	assign r_key     = {key_r_high_q, key_r_low_q} & pam_pkg::R_CLAMP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_r_low_q  <= '0;
			key_r_high_q <= '0;
			key_s_low_q  <= '0;
			key_s_high_q <= '0;
			aead_mode_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (pam_pkg::cfg_index_t'(cfg_index))
				pam_pkg::CFG_R_LOW:  key_r_low_q  <= cfg_data;
				pam_pkg::CFG_R_HIGH: key_r_high_q <= cfg_data;
				pam_pkg::CFG_S_LOW:  key_s_low_q  <= cfg_data;
				pam_pkg::CFG_S_HIGH: key_s_high_q <= cfg_data;
				pam_pkg::CFG_MODE:   aead_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pam_front #(
		.LenBits (LENGTH_COUNTER_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.aead_mode (aead_mode_q),
		.q_full    (q_full),
		.push      (push),
		.job       (wr_job)
	);

	pam_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_job   (rd_job)
	);

	pam_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (rd_job),
		.pop      (pop),
		.r_key    (r_key),
		.s_key    ({key_s_high_q, key_s_low_q}),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== hdl/pam_checker.sv =====
`include "poly1305_aead_mac_top_macros.svh"

module pam_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [15:0]  s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [2:0]   cfg_index,
	input logic [63:0]  cfg_data
);

	// a stalled tag holds until taken
	`PAM_ASSERT(a_tag_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "tag dropped or changed while stalled")

	// the front sequences its finish work before taking more bytes
	`PAM_ASSERT(a_finish_busy, s_tvalid && s_tready && s_tdata[1:0] == pam_pkg::OP_FINISH |=> !s_tready, "input taken during finish sequence")

	`PAM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "tag valid during reset")

endmodule

bind poly1305_aead_mac_top pam_checker u_pam_checker (.*);
